FILE: rtl/swrf_pkg.sv
package swrf_pkg;

   // Store geometry and sample width
   localparam int WINDOW_MAX  = 16;
   localparam int SAMPLE_BITS = 16;
   localparam int IDX_BITS    = $clog2(WINDOW_MAX);
   localparam int CNT_BITS    = $clog2(WINDOW_MAX + 1);

   // Register file layout
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 5;
   localparam int LEN_BITS      = 5;
   localparam int RANK_BITS     = 4;

   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_LEN = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RANK_INDEX = 2'd1;

   localparam logic [LEN_BITS-1:0]  WINDOW_LEN_RESET = 5'd9;
   localparam logic [RANK_BITS-1:0] RANK_INDEX_RESET = 4'd4;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [IDX_BITS-1:0]           idx_type;
   typedef logic [CNT_BITS-1:0]           cnt_type;

   // Outcome of one compare of a window element against the candidate
   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_result_type;

endpackage

FILE: rtl/swrf_mem.sv
module swrf_mem (
   input  logic                 clock,
   input  logic                 wr_en,
   input  swrf_pkg::idx_type    wr_addr,
   input  swrf_pkg::sample_type wr_data,
   input  swrf_pkg::idx_type    rd_addr,
   output swrf_pkg::sample_type rd_data
);
   import swrf_pkg::*;

   sample_type mem_ff [WINDOW_MAX];
   sample_type rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/swrf_cmp.sv
module swrf_cmp (
   input  swrf_pkg::sample_type     elem,
   input  swrf_pkg::sample_type     cand,
   output swrf_pkg::cmp_result_type result
);
   import swrf_pkg::*;

   // Two's complement signed order of element against candidate
   always_comb begin
      result.lt = (elem < cand);
      result.eq = (elem == cand);
   end

endmodule

FILE: rtl/sliding_window_rank_filter.sv
// Channel | Direction | Ports
// req     | in        | req_valid, req_ready, req_sample
// rsp     | out       | rsp_valid, rsp_ready, rsp_ranked_value
// csr     | in        | csr_valid, csr_ready, csr_index, csr_wdata
//
// Each window element in turn is taken as a candidate and compared with every
// window element through one shared comparator, one compare per cycle, until a
// candidate's less-than and less-or-equal counts bracket the rank.
// Each candidate is read from the store, loaded, then compared across the window;
// the single store read port serves both the candidate and the window elements.
// Synchronous reset clears control state; the store needs no clearing pass.
// req_ready is low while an item is in progress; a stalled result holds the
// sequencer until rsp_ready, the csr channel is always ready.
module sliding_window_rank_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  swrf_pkg::sample_type                req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output swrf_pkg::sample_type                rsp_ranked_value,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [swrf_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [swrf_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import swrf_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RDC  = 3'd1;
   localparam logic [2:0] S_LDC  = 3'd2;
   localparam logic [2:0] S_CMP  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [LEN_BITS-1:0]  window_len_ff;
   logic [RANK_BITS-1:0] rank_index_ff;
   idx_type              oldest_ff;
   idx_type              newest_ff;
   cnt_type              fill_ff;
   sample_type           first_ff;
   cnt_type              len_m1_ff;
   cnt_type              rank_ff;
   idx_type              cand_idx_ff, cand_idx_in;
   idx_type              cmp_idx_ff, cmp_idx_in;
   cnt_type              less_ff, less_in;
   cnt_type              le_ff, le_in;
   sample_type           cand_ff, cand_in;
   logic                 rd_live_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   sample_type           rsp_data_ff;

   logic                 accept;
   cnt_type              len_eff;
   cnt_type              rank_eff;
   idx_type              rd_age;
   idx_type              rd_addr;
   sample_type           rd_data;
   sample_type           rd_value;
   cmp_result_type       cmp_res;
   logic                 last_cmp;
   logic                 found;
   logic                 out_free;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Clamp window length to 1..WINDOW_MAX and the rank to the window
   always_comb begin
      if (window_len_ff == '0) begin
         len_eff = cnt_type'(1);
      end else if (32'(window_len_ff) > WINDOW_MAX) begin
         len_eff = cnt_type'(WINDOW_MAX);
      end else begin
         len_eff = cnt_type'(window_len_ff);
      end
      if (cnt_type'(rank_index_ff) >= len_eff) begin
         rank_eff = len_eff - cnt_type'(1);
      end else begin
         rank_eff = cnt_type'(rank_index_ff);
      end
   end

   // Read address: age counted back from the newest slot, modulo the store
   assign rd_age = (state_ff == S_RDC) ? cand_idx_ff : cmp_idx_in;
   always_comb begin
      if (newest_ff >= rd_age) begin
         rd_addr = newest_ff - rd_age;
      end else begin
         rd_addr = idx_type'(32'(newest_ff) + WINDOW_MAX - 32'(rd_age));
      end
   end

   swrf_mem u_mem (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (oldest_ff),
      .wr_data (req_sample),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Slots older than the fill count still hold the first sample
   assign rd_value = rd_live_ff ? rd_data : first_ff;

   swrf_cmp u_cmp (
      .elem   (rd_value),
      .cand   (cand_ff),
      .result (cmp_res)
   );

   // Counts including the current compare bracket the rank
   assign last_cmp = (cnt_type'(cmp_idx_ff) == len_m1_ff);
   assign found    = ((less_ff + cnt_type'(cmp_res.lt)) <= rank_ff) &&
                     (rank_ff < (le_ff + cnt_type'(cmp_res.lt || cmp_res.eq)));

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cand_idx_in  = cand_idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      less_in      = less_ff;
      le_in        = le_ff;
      cand_in      = cand_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            cmp_idx_in = '0;
            if (accept) begin
               cand_idx_in = '0;
               state_in    = S_RDC;
            end
         end
         S_RDC: begin
            cmp_idx_in = '0;
            state_in   = S_LDC;
         end
         S_LDC: begin
            cand_in    = rd_value;
            less_in    = '0;
            le_in      = '0;
            cmp_idx_in = '0;
            state_in   = S_CMP;
         end
         S_CMP: begin
            if (cmp_res.lt) begin
               less_in = less_ff + cnt_type'(1);
            end
            if (cmp_res.lt || cmp_res.eq) begin
               le_in = le_ff + cnt_type'(1);
            end
            cmp_idx_in = cmp_idx_ff + idx_type'(1);
            if (last_cmp) begin
               if (found) begin
                  state_in = S_OUT;
               end else begin
                  cand_idx_in = cand_idx_ff + idx_type'(1);
                  state_in    = S_RDC;
               end
            end
         end
         S_OUT: begin
            cmp_idx_in = '0;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         window_len_ff <= WINDOW_LEN_RESET;
         rank_index_ff <= RANK_INDEX_RESET;
         oldest_ff     <= '0;
         fill_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_WINDOW_LEN) begin
               window_len_ff <= LEN_BITS'(csr_wdata);
            end else if (csr_index == CSR_RANK_INDEX) begin
               rank_index_ff <= RANK_BITS'(csr_wdata);
            end
         end
         if (accept) begin
            if (32'(oldest_ff) == WINDOW_MAX - 1) begin
               oldest_ff <= '0;
            end else begin
               oldest_ff <= oldest_ff + idx_type'(1);
            end
            if (32'(fill_ff) < WINDOW_MAX) begin
               fill_ff <= fill_ff + cnt_type'(1);
            end
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cand_idx_ff <= cand_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      less_ff     <= less_in;
      le_ff       <= le_in;
      cand_ff     <= cand_in;
      rd_live_ff  <= (cnt_type'(rd_age) < fill_ff);
      if (accept) begin
         newest_ff <= oldest_ff;
         len_m1_ff <= len_eff - cnt_type'(1);
         rank_ff   <= rank_eff;
         if (fill_ff == '0) begin
            first_ff <= req_sample;
         end
      end
      if (state_ff == S_OUT && out_free) begin
         rsp_data_ff <= cand_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ranked_value = rsp_data_ff;

   // A new result appears only from the output step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside output step");

   // Compare index never runs past the window
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (cnt_type'(cmp_idx_ff) <= len_m1_ff))
      else $error("compare index beyond window");

   // Less-or-equal count always covers the less-than count
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (le_ff >= less_ff))
      else $error("rank counts inconsistent");

   // An accepted item starts the candidate scan
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_RDC) && (cand_idx_ff == '0))
      else $error("scan did not start after accept");

endmodule

FILE: dv/sliding_window_rank_filter_tb.sv
module sliding_window_rank_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import swrf_pkg::*;

   // Register indexes past the end of the register file; writes are dropped
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_HI = 2'd3;

   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   localparam int RANDOM_ITEMS = 1500;
   localparam int TAIL_CYCLES  = 320;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   sample_type               req_sample = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   sample_type               rsp_ranked_value;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   sliding_window_rank_filter DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ranked_value (rsp_ranked_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Mirror of the filter: sample history, write pointer and registers
   sample_type          win_mem [WINDOW_MAX];
   idx_type             wr_slot = '0;
   logic                primed = 1'b0;
   logic [LEN_BITS-1:0]  cfg_len = WINDOW_LEN_RESET;
   logic [RANK_BITS-1:0] cfg_rank = RANK_INDEX_RESET;

   sample_type pending_samples [$];
   sample_type expected_ranks [$];
   int         queued_total = 0;
   int         accepted_total = 0;
   int         fail_count = 0;

   logic quiet_phase = 1'b0;
   logic drain_pause = 1'b0;
   logic drv_on;
   int   drv_wait = 0;
   int   mon_wait = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   // Store the new sample, then pick the window value whose less-than and
   // less-or-equal counts bracket the effective rank
   function automatic sample_type rank_of_window(input sample_type smp);
      sample_type  view [WINDOW_MAX];
      sample_type  found;
      int unsigned span, pick, lt_cnt, le_cnt;
      int          i, c;
      if (!primed) begin
         for (i = 0; i < WINDOW_MAX; i++) win_mem[i] = smp;
         primed = 1'b1;
      end
      win_mem[wr_slot] = smp;
      if (cfg_len == 0) span = 1;
      else if (cfg_len > WINDOW_MAX) span = WINDOW_MAX;
      else span = 32'(cfg_len);
      pick = (32'(cfg_rank) >= span) ? span - 1 : 32'(cfg_rank);
      for (i = 0; i < span; i++) view[i] = win_mem[idx_type'(wr_slot - i)];
      wr_slot = wr_slot + 1'b1;
      found = view[0];
      for (c = 0; c < span; c++) begin
         lt_cnt = 0;
         le_cnt = 0;
         for (i = 0; i < span; i++) begin
            if (view[i] < view[c]) lt_cnt++;
            if (view[i] <= view[c]) le_cnt++;
         end
         if (lt_cnt <= pick && pick < le_cnt) found = view[c];
      end
      return found;
   endfunction

   // Mix of full-range values, extremes and clusters that produce ties
   function automatic sample_type draw_sample(input sample_type base);
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return SAMPLE_MIN;
               1: return SAMPLE_MAX;
               2: return '0;
               default: return '1;
            endcase
         end
         1, 2, 3: return base + sample_type'($urandom_range(0, 5));
         default: return sample_type'($urandom);
      endcase
   endfunction

   task automatic queue_sample(input sample_type smp);
      pending_samples.push_back(smp);
      queued_total++;
   endtask

   // Blocks until every queued item is taken and every result is back
   task automatic wait_drained();
      while (accepted_total != queued_total || expected_ranks.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_WINDOW_LEN: cfg_len = data;
         CSR_RANK_INDEX: cfg_rank = data[RANK_BITS-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   // Request driver: one item at a time, random gap after each acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         drv_wait = 0;
         drain_pause = 1'b0;
      end else begin
         drv_on = req_valid;
         if (req_valid && req_ready) begin
            expected_ranks.push_back(rank_of_window(req_sample));
            accepted_total++;
            drv_on = 1'b0;
            drv_wait = quiet_phase ? 0 : $urandom_range(0, 15);
            // now and then hold off until the block has fully drained
            if ($urandom_range(0, 39) == 0) drain_pause = 1'b1;
         end
         if (drain_pause && expected_ranks.size() == 0) drain_pause = 1'b0;
         if (!drv_on) begin
            if (drv_wait > 0) begin
               drv_wait--;
            end else if (!drain_pause && pending_samples.size() > 0) begin
               drv_on = 1'b1;
               req_sample <= pending_samples.pop_front();
            end
         end
         req_valid <= drv_on;
      end
   end

   // Result monitor: stall count drawn per item, counted down while valid
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         mon_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_ranks.size() == 0) begin
               $display("%0t unexpected result: expected none actual %0d",
                        $time, rsp_ranked_value);
               fail_count++;
            end else if (rsp_ranked_value !== expected_ranks[0]) begin
               $display("%0t ranked_value mismatch: expected %0d actual %0d",
                        $time, expected_ranks[0], rsp_ranked_value);
               fail_count++;
               void'(expected_ranks.pop_front());
            end else begin
               void'(expected_ranks.pop_front());
            end
            mon_wait = quiet_phase ? 0 : $urandom_range(0, 15);
         end else if (rsp_valid && mon_wait > 0) begin
            mon_wait--;
         end
         rsp_ready <= (mon_wait == 0);
      end
   end

   // Stimulus: directed phases, then random configurations and samples
   initial begin
      logic [CSR_DATA_BITS-1:0] len_pick;
      sample_type               base;
      int                       random_sent;
      int                       n;
      random_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset registers; first sample fills the store, then extremes
      queue_sample(SAMPLE_MAX);
      queue_sample(SAMPLE_MIN);
      queue_sample('0);
      queue_sample('1);
      queue_sample(sample_type'(1));
      queue_sample(SAMPLE_MIN);
      queue_sample(SAMPLE_MIN);
      wait_drained();

      // dropped writes, then full window reaching back into the fill
      write_csr(CSR_SPARE_LO, 5'd0);
      write_csr(CSR_SPARE_HI, 5'd31);
      write_csr(CSR_WINDOW_LEN, 5'd16);
      write_csr(CSR_RANK_INDEX, 5'd15);
      queue_sample(sample_type'(5));
      queue_sample(sample_type'(5));
      queue_sample(sample_type'(-5));
      wait_drained();

      // zero length acts as one
      write_csr(CSR_WINDOW_LEN, 5'd0);
      write_csr(CSR_RANK_INDEX, 5'd0);
      queue_sample(sample_type'(100));
      queue_sample(sample_type'(-100));
      wait_drained();

      // length above the store saturates; rank upper bit is dropped
      write_csr(CSR_WINDOW_LEN, 5'd31);
      write_csr(CSR_RANK_INDEX, 5'd23);
      queue_sample(SAMPLE_MAX);
      queue_sample(SAMPLE_MIN);
      queue_sample(sample_type'(3));
      wait_drained();

      // rank past the window clips to the top
      write_csr(CSR_WINDOW_LEN, 5'd4);
      write_csr(CSR_RANK_INDEX, 5'd15);
      queue_sample(sample_type'(2));
      queue_sample(sample_type'(-2));
      queue_sample(sample_type'(9));
      wait_drained();

      write_csr(CSR_WINDOW_LEN, 5'd1);
      write_csr(CSR_RANK_INDEX, 5'd9);
      queue_sample(sample_type'(1));
      queue_sample(SAMPLE_MIN);
      wait_drained();

      // smallest of a full window, with the two newest samples tied
      write_csr(CSR_WINDOW_LEN, 5'd16);
      write_csr(CSR_RANK_INDEX, 5'd0);
      queue_sample('1);
      queue_sample('1);
      wait_drained();

      // random phases, short windows favored to keep the run brisk
      while (random_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 4) == 0)
            write_csr($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI,
                      CSR_DATA_BITS'($urandom_range(0, 31)));
         if ($urandom_range(0, 3) != 0) begin
            n = $urandom_range(0, 9);
            if (n < 6) len_pick = CSR_DATA_BITS'($urandom_range(1, 8));
            else if (n < 9) len_pick = CSR_DATA_BITS'($urandom_range(9, 16));
            else len_pick = CSR_DATA_BITS'($urandom_range(0, 31));
            write_csr(CSR_WINDOW_LEN, len_pick);
         end
         if ($urandom_range(0, 3) != 0)
            write_csr(CSR_RANK_INDEX, CSR_DATA_BITS'($urandom_range(0, 31)));
         quiet_phase = ($urandom_range(0, 3) == 0);
         base = sample_type'($urandom);
         n = $urandom_range(10, 60);
         repeat (n) queue_sample(draw_sample(base));
         random_sent += n;
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #8_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
